### hdl/compacting_unique_value_set_unit_macros.svh
// Assertion macros used by the top module of the compacting unique value set unit.
`ifndef COMPACTING_UNIQUE_VALUE_SET_UNIT_MACROS_SVH
`define COMPACTING_UNIQUE_VALUE_SET_UNIT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define CUVS_ASSERT_SAME(name, trig, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("cuvs assertion failed");

// The condition must hold in the cycle after the trigger.
`define CUVS_ASSERT_NEXT(name, trig, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("cuvs assertion failed");

`endif

### hdl/cuvs_pkg.sv
// Package with the sizes, codes and types of the compacting unique value set unit.
package cuvs_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 64;
  localparam int POS_W    = 4;
  localparam int CNTO_W   = 5;

  typedef logic [1:0]       cmd_t;
  typedef logic [1:0]       status_t;
  typedef logic [VAL_W-1:0] value_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam cmd_t CMD_LOOKUP = 2'd0;
  localparam cmd_t CMD_ADD    = 2'd1;
  localparam cmd_t CMD_REMOVE = 2'd2;

  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_PRESENT = 2'd1;
  localparam status_t ST_ABSENT  = 2'd2;
  localparam status_t ST_FULL    = 2'd3;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  function automatic logic [POS_W-1:0] to_pos(input idx_t idx);
    logic [31:0] t;
    t = 32'(idx);
    return t[POS_W-1:0];
  endfunction

  function automatic logic [CNTO_W-1:0] to_cnt(input cnt_t cnt);
    logic [31:0] t;
    t = 32'(cnt);
    return t[CNTO_W-1:0];
  endfunction

endpackage

### hdl/cuvs_if.sv
// Handshake interfaces for the command and result channels.
interface cuvs_in_if;
  logic                valid;
  logic                ready;
  cuvs_pkg::cmd_t      command;
  cuvs_pkg::value_t    value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface cuvs_out_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [cuvs_pkg::POS_W-1:0]     position;
  logic [cuvs_pkg::CNTO_W-1:0]    count_after;
  cuvs_pkg::status_t              status;

  modport source (output valid, output found, output position, output count_after,
                  output status, input ready);
  modport sink   (input valid, input found, input position, input count_after,
                  input status, output ready);
endinterface

### hdl/cuvs_cell.sv
// One storage cell of the set: holds an entry, compares it and loads the incoming value or its neighbour's entry.
module cuvs_cell (
  input  logic                clk,
  input  cuvs_pkg::value_t    value,
  input  cuvs_pkg::value_t    nb_entry,
  input  logic                live,
  input  cuvs_pkg::cell_ctl_t ctl,
  output cuvs_pkg::value_t    entry,
  output logic                hit
);

  cuvs_pkg::value_t entry_r;
  cuvs_pkg::value_t entry_nxt;

  always_comb begin
    if (ctl.load) begin
      entry_nxt = value;
    end else if (ctl.shift) begin
      entry_nxt = nb_entry;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign hit   = live && (entry_r == value);

endmodule

### hdl/compacting_unique_value_set_unit.sv
// Top level of the compacting unique value set unit: row of cells, count and result register.
// The set keeps up to cuvs_pkg::CAPACITY distinct 64-bit words packed at the low
// entries. Every cell compares its word with the incoming value in parallel, and a
// remove moves every later entry down by one in a single neighbour-to-neighbour
// transfer, so a new command is taken every cycle
// while the result register is empty or being emptied; results come out in the cycle
// after the command is taken. Stored words start undefined and only entries below
// the count are ever compared, so no clearing is needed after reset.
`include "compacting_unique_value_set_unit_macros.svh"

module compacting_unique_value_set_unit (
  input logic       clk,
  input logic       rst_n,
  cuvs_in_if.sink   in_chan,
  cuvs_out_if.source out_chan
);

  localparam int N = cuvs_pkg::CAPACITY;

  cuvs_pkg::value_t    entry  [N];
  logic [N-1:0]        hit_vec;
  logic [N-1:0]        live;
  cuvs_pkg::cell_ctl_t ctl    [N];

  cuvs_pkg::cnt_t count_r;
  cuvs_pkg::cnt_t count_nxt;

  logic                          out_valid_r;
  logic                          found_r;
  logic [cuvs_pkg::POS_W-1:0]    position_r;
  logic [cuvs_pkg::CNTO_W-1:0]   count_after_r;
  cuvs_pkg::status_t             status_r;

  logic              accept;
  logic              any_hit;
  logic              full;
  logic              is_add;
  logic              is_rem;
  logic              do_add;
  logic              do_rem;
  cuvs_pkg::idx_t    hit_idx;
  cuvs_pkg::idx_t    pos;
  cuvs_pkg::status_t status;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      cuvs_pkg::value_t nb;
      if (gi == N - 1) begin : g_last
        assign nb = '0;
      end else begin : g_mid
        assign nb = entry[gi+1];
      end

      assign live[gi]      = cuvs_pkg::cnt_t'(gi) < count_r;
      assign ctl[gi].load  = do_add && (cuvs_pkg::cnt_t'(gi) == count_r);
      assign ctl[gi].shift = do_rem && (cuvs_pkg::idx_t'(gi) >= hit_idx)
                             && (cuvs_pkg::cnt_t'(gi + 1) < count_r);

      cuvs_cell u_cell (
        .clk      (clk),
        .value    (in_chan.value),
        .nb_entry (nb),
        .live     (live[gi]),
        .ctl      (ctl[gi]),
        .entry    (entry[gi]),
        .hit      (hit_vec[gi])
      );
    end
  endgenerate

  // Stored words are distinct, so at most one cell hits and its index is an OR.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (hit_vec[i]) begin
        hit_idx = hit_idx | cuvs_pkg::idx_t'(i);
      end
    end
  end

  assign any_hit = |hit_vec;
  assign full    = count_r >= cuvs_pkg::cnt_t'(N);
  assign is_add  = in_chan.command == cuvs_pkg::CMD_ADD;
  assign is_rem  = in_chan.command == cuvs_pkg::CMD_REMOVE;
  assign do_add  = accept && is_add && !any_hit && !full;
  assign do_rem  = accept && is_rem && any_hit;

  always_comb begin
    pos       = any_hit ? hit_idx : '0;
    status    = cuvs_pkg::ST_DONE;
    count_nxt = count_r;
    if (is_add) begin
      if (any_hit) begin
        status = cuvs_pkg::ST_PRESENT;
      end else if (full) begin
        status = cuvs_pkg::ST_FULL;
      end else begin
        pos = count_r[cuvs_pkg::IDX_W-1:0];
      end
    end else if (is_rem) begin
      if (!any_hit) begin
        status = cuvs_pkg::ST_ABSENT;
      end
    end
    if (do_add) begin
      count_nxt = count_r + cuvs_pkg::cnt_t'(1);
    end else if (do_rem) begin
      count_nxt = count_r - cuvs_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      found_r       <= any_hit;
      position_r    <= cuvs_pkg::to_pos(pos);
      count_after_r <= cuvs_pkg::to_cnt(count_nxt);
      status_r      <= status;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.found       = found_r;
  assign out_chan.position    = position_r;
  assign out_chan.count_after = count_after_r;
  assign out_chan.status      = status_r;

  `CUVS_ASSERT_SAME(a_count_bound, 1'b1, count_r <= cuvs_pkg::cnt_t'(N))
  `CUVS_ASSERT_SAME(a_single_hit, 1'b1, $onehot0(hit_vec))
  `CUVS_ASSERT_NEXT(a_add_grows, do_add, count_r == $past(count_r) + cuvs_pkg::cnt_t'(1))
  `CUVS_ASSERT_NEXT(a_rem_shrinks, do_rem, count_r == $past(count_r) - cuvs_pkg::cnt_t'(1))
  `CUVS_ASSERT_SAME(a_one_load, 1'b1, $countones({do_add, do_rem}) <= 1)

endmodule

### sim/cuvs_result_checker.sv
// Checker for the compacting unique value set unit: tracks the set and checks every result.
`timescale 1ns / 100ps

module cuvs_result_checker
  import cuvs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  cuvs_in_if   in_mon,
  cuvs_out_if  out_mon,
  output int   failures,
  output int   outstanding
);

  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  position;
    logic [CNTO_W-1:0] count_after;
    status_t           status;
  } set_result_t;

  value_t      held_words [CAPACITY];
  int          held_count;
  set_result_t due_results [$];

  initial begin
    failures    = 0;
    outstanding = 0;
    held_count  = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns  mismatch: %s", $time, what);
    failures++;
  endtask

  function automatic set_result_t apply_command(input cmd_t cmd, input value_t word);
    set_result_t r;
    logic        hit;
    int          hit_idx;
    hit     = 1'b0;
    hit_idx = 0;
    for (int i = 0; i < held_count; i++) begin
      if (!hit && held_words[i] == word) begin
        hit     = 1'b1;
        hit_idx = i;
      end
    end
    r.found    = hit;
    r.position = '0;
    r.status   = ST_DONE;
    case (cmd)
      CMD_ADD: begin
        if (hit) begin
          r.position = POS_W'(hit_idx);
          r.status   = ST_PRESENT;
        end else if (held_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          held_words[held_count] = word;
          r.position = POS_W'(held_count);
          held_count++;
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          for (int i = hit_idx; i + 1 < held_count; i++) held_words[i] = held_words[i + 1];
          held_count--;
          r.position = POS_W'(hit_idx);
        end else begin
          r.status = ST_ABSENT;
        end
      end
      default: begin
        r.position = hit ? POS_W'(hit_idx) : '0;
      end
    endcase
    r.count_after = CNTO_W'(held_count);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    set_result_t want;
    if (!rst_n) begin
      held_count = 0;
      due_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = due_results.pop_front();
          if (out_mon.found !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b", out_mon.found, want.found));
          if (out_mon.position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      out_mon.position, want.position));
          if (out_mon.count_after !== want.count_after)
            report_mismatch($sformatf("count_after %0d, expected %0d",
                                      out_mon.count_after, want.count_after));
          if (out_mon.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_mon.status, want.status));
        end
      end
      if (in_mon.valid && in_mon.ready)
        due_results.push_back(apply_command(in_mon.command, in_mon.value));
    end
    outstanding <= due_results.size();
  end

endmodule

### sim/compacting_unique_value_set_unit_tb.sv
// Testbench top for the compacting unique value set unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module compacting_unique_value_set_unit_tb;
  import cuvs_pkg::*;

  localparam cmd_t CMD_UNUSED   = 2'd3;
  localparam int   POOL_SIZE    = 20;
  localparam int   PHASES       = 15;
  localparam int   PHASE_ITEMS  = 110;
  localparam int   IDLE_LIMIT   = 3000;

  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  int   failures;
  int   outstanding;
  int   inputs_taken = 0;
  int   idle_cycles  = 0;
  int   burst_left   = 4;

  cuvs_in_if  in_bus ();
  cuvs_out_if out_bus ();

  compacting_unique_value_set_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  cuvs_result_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) inputs_taken <= inputs_taken + 1;
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Entered and left just after a falling edge; one transfer per call.
  task automatic offer(input cmd_t cmd, input value_t word);
    int gap;
    in_bus.valid   <= 1'b1;
    in_bus.command <= cmd;
    in_bus.value   <= word;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      gap        = $urandom_range(8, 1);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(60, 25) : $urandom_range(12, 1);
      in_bus.valid   <= 1'b0;
      in_bus.command <= cmd_t'($urandom_range(3));
      in_bus.value   <= {$urandom, $urandom};
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // The receiver stalls on a pattern of its own, with two long hold-offs that fill the block.
  initial begin : receiver
    rx_mode_t mode;
    int       stretch;
    int       holds_done;
    holds_done    = 0;
    out_bus.ready = 1'b0;
    forever begin
      if (holds_done < 2 && inputs_taken >= (holds_done == 0 ? 400 : 1200)) begin
        repeat (holds_done == 0 ? 300 : 250) begin
          @(negedge clk);
          out_bus.ready <= 1'b0;
        end
        holds_done++;
      end else begin
        mode    = rx_mode_t'($urandom_range(3));
        stretch = $urandom_range(200, 20);
        for (int c = 0; c < stretch; c++) begin
          @(negedge clk);
          case (mode)
            RX_FREE:   out_bus.ready <= 1'b1;
            RX_COIN:   out_bus.ready <= 1'($urandom_range(1));
            RX_SPARSE: out_bus.ready <= ($urandom_range(3) == 0);
            default:   out_bus.ready <= (c % 3 == 0);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    value_t pool [POOL_SIZE];
    value_t word;
    cmd_t   cmd;
    int     r;
    int     w_add;
    int     w_rem;
    in_bus.valid   = 1'b0;
    in_bus.command = CMD_LOOKUP;
    in_bus.value   = '0;
    rst_n          = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty set, duplicates, the unused code, removal with a shift, filling and a full add.
    offer(CMD_LOOKUP, '0);
    offer(CMD_REMOVE, '1);
    offer(CMD_ADD, '0);
    offer(CMD_ADD, '1);
    offer(CMD_ADD, '0);
    offer(CMD_LOOKUP, '1);
    offer(CMD_UNUSED, '1);
    offer(CMD_REMOVE, '0);
    offer(CMD_LOOKUP, '1);
    for (int k = 1; k < CAPACITY; k++) offer(CMD_ADD, 64'h1 << (4 * k));
    offer(CMD_ADD, 64'h8000_0000_0000_0001);
    offer(CMD_REMOVE, '1);
    offer(CMD_REMOVE, 64'h1 << 60);
    drain();

    // Near-miss values differ from a partner in a single bit.
    pool[0] = '0;
    pool[1] = '1;
    for (int k = 2; k < 11; k++) pool[k] = {$urandom, $urandom};
    for (int k = 11; k < POOL_SIZE; k++)
      pool[k] = pool[k - 9] ^ (64'h1 << $urandom_range(63));

    for (int phase = 0; phase < PHASES; phase++) begin
      w_add = (phase % 3 == 0) ? 60 : (phase % 3 == 1) ? 15 : 38;
      w_rem = (phase % 3 == 0) ? 15 : (phase % 3 == 1) ? 60 : 32;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        if (r < w_add)              cmd = CMD_ADD;
        else if (r < w_add + w_rem) cmd = CMD_REMOVE;
        else if (r < 95)            cmd = CMD_LOOKUP;
        else                        cmd = CMD_UNUSED;
        if ($urandom_range(99) < 85) word = pool[$urandom_range(POOL_SIZE - 1)];
        else                         word = {$urandom, $urandom};
        offer(cmd, word);
      end
      if (phase % 5 == 4) drain();
    end

    drain();
    repeat (10) @(negedge clk);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### compacting_unique_value_set_unit.f
+incdir+hdl
hdl/cuvs_pkg.sv
hdl/cuvs_if.sv
hdl/cuvs_cell.sv
hdl/compacting_unique_value_set_unit.sv
sim/cuvs_result_checker.sv
sim/compacting_unique_value_set_unit_tb.sv
